### sv/tape_edge_bit_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Tape edge bit decoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TAPE_EDGE_BIT_DECODER_TOP_ASSERT_SVH
`define TAPE_EDGE_BIT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tape edge bit decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TEBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tape edge bit decoder check failed");

`endif

### sv/tebd_pkg.sv
// ----------------------------------------------------------------------------
// Tape edge bit decoder package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package tebd_pkg;

	localparam int CYCLE_W   = 64;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int BYTE_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SHORT_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT   = 1'd1;

	localparam logic [CFG_W-1:0] SHORT_THRESHOLD_RST = 16'd739;
	localparam logic [CFG_W-1:0] SILENCE_LIMIT_RST   = 16'd7808;

	// Item codes.
	localparam logic FUNC_EDGE   = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	// Outcome of one processed item, handed from the core to the output stage.
	typedef struct packed {
		logic              emit;
		logic [BYTE_W-1:0] byte_value;
	} tebd_result_t;

endpackage

### sv/tebd_in_if.sv
// ----------------------------------------------------------------------------
// Tape edge bit decoder input channel
// Valid/ready channel carrying one edge or finish item per beat.
// ----------------------------------------------------------------------------
interface tebd_in_if
	import tebd_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               func;
	logic [CYCLE_W-1:0] cycle;

	modport source (output valid, output func, output cycle, input ready);
	modport sink (input valid, input func, input cycle, output ready);
endinterface

### sv/tebd_out_if.sv
// ----------------------------------------------------------------------------
// Tape edge bit decoder output channel
// Valid/ready channel carrying one decoded byte per beat.
// ----------------------------------------------------------------------------
interface tebd_out_if
	import tebd_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;

	modport source (output valid, output byte_value, input ready);
	modport sink (input valid, input byte_value, output ready);
endinterface

### sv/tebd_core.sv
// ----------------------------------------------------------------------------
// Tape edge bit decoder core
// Half period measurement, grouping, bit decision and byte assembly state.
// ----------------------------------------------------------------------------
module tebd_core
	import tebd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               func,
	input  logic [CYCLE_W-1:0] cycle,
	input  logic [CFG_W-1:0]   short_threshold,
	input  logic [CFG_W-1:0]   silence_limit,
	output tebd_result_t       res
);

	logic               edge_seen_q;
	logic [CYCLE_W-1:0] last_edge_q;
	logic [1:0]         halves_q;
	logic [2:0]         shorts_q;
	logic [2:0]         bits_q;
	logic [BYTE_W-1:0]  shift_q;
	logic               burst_open_q;
	logic               last_short_q;

	logic [CYCLE_W-1:0] half;
	logic               high_zero;
	logic               silent;
	logic               is_short;
	logic               take;
	logic               taken_short;
	logic [2:0]         shorts_nx;
	logic               group_done;
	logic               byte_done;
	logic [BYTE_W-1:0]  shift_nx;

	// The half period wraps modulo 2^64, as the cycle counter does.
	assign half      = cycle - last_edge_q;
	assign high_zero = (half[CYCLE_W-1:CFG_W] == '0);
	assign silent    = !high_zero || (half[CFG_W-1:0] > silence_limit);
	assign is_short  = high_zero && (half[CFG_W-1:0] < short_threshold);

	// A finish item replays the last half of an open burst.
	assign take        = (func == FUNC_FINISH) ? burst_open_q : (edge_seen_q && !silent);
	assign taken_short = (func == FUNC_FINISH) ? last_short_q : is_short;
	assign shorts_nx   = shorts_q + {2'b00, taken_short};
	assign group_done  = (halves_q == 2'd3);
	assign byte_done   = group_done && (bits_q == 3'd7);
	assign shift_nx    = {shift_q[BYTE_W-2:0], (shorts_nx >= 3'd2)};

	assign res.emit       = fire && take && byte_done;
	assign res.byte_value = shift_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_seen_q  <= 1'b0;
			last_edge_q  <= '0;
			halves_q     <= '0;
			shorts_q     <= '0;
			bits_q       <= '0;
			shift_q      <= '0;
			burst_open_q <= 1'b0;
			last_short_q <= 1'b0;
		end else if (fire) begin
			if (func == FUNC_FINISH || (edge_seen_q && silent)) begin
				halves_q     <= '0;
				shorts_q     <= '0;
				bits_q       <= '0;
				shift_q      <= '0;
				burst_open_q <= 1'b0;
				last_short_q <= 1'b0;
			end else if (take) begin
				burst_open_q <= 1'b1;
				last_short_q <= taken_short;
				if (!group_done) begin
					halves_q <= halves_q + 2'd1;
					shorts_q <= shorts_nx;
				end else begin
					halves_q <= '0;
					shorts_q <= '0;
					if (byte_done) begin
						bits_q  <= '0;
						shift_q <= '0;
					end else begin
						bits_q  <= bits_q + 3'd1;
						shift_q <= shift_nx;
					end
				end
			end
			if (func == FUNC_FINISH) begin
				edge_seen_q <= 1'b0;
			end else begin
				edge_seen_q <= 1'b1;
				last_edge_q <= cycle;
			end
		end
	end

endmodule

### sv/tape_edge_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// Tape edge bit decoder top level
// Turns cassette edge timestamps into decoded data bytes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload               Beat meaning
//   din      in         func, cycle[63:0]     one edge or one finish request
//   dout     out        byte_value[7:0]       one decoded byte, MSB first
//   cfg      in         cfg_index, cfg_data   register write, no handshake
//
// A beat is captured in the stage 1 register and run through the core when
// stage 1 fires; a byte it completes is loaded into the output register.
// One beat is accepted every cycle while no waiting byte holds stage 1, as the
// core is one 64-bit subtract, two 16-bit compares and small counter updates.
// While a waiting byte is not taken, stage 1 holds its item, emitting or not.
// Reset (arst_n low) clears the decoder and the pipeline and reloads the
// configuration registers with their reset values.
//
module tape_edge_bit_decoder_top
	import tebd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	tebd_in_if.sink              din,
	tebd_out_if.source           dout
);

`include "tape_edge_bit_decoder_top_assert.svh"

	logic [CFG_W-1:0]   short_threshold_q;
	logic [CFG_W-1:0]   silence_limit_q;

	logic               vld_s1;
	logic               func_s1;
	logic [CYCLE_W-1:0] cycle_s1;

	logic               out_vld_q;
	logic [BYTE_W-1:0]  out_byte_q;

	logic               s1_fire;
	logic               in_fire;
	tebd_result_t       res;

	// Configuration registers. Writes must only happen while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_threshold_q <= SHORT_THRESHOLD_RST;
			silence_limit_q   <= SILENCE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_THRESHOLD: short_threshold_q <= cfg_data;
				REG_SILENCE_LIMIT:   silence_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 may process whenever the output register is free or draining.
	// It could go ahead even more often, since most items emit nothing, but
	// holding it keeps the output decision independent of the core result.
	assign s1_fire   = vld_s1 && (!out_vld_q || dout.ready);
	assign din.ready = !vld_s1 || s1_fire;
	assign in_fire   = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (din.ready) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1  <= din.func;
			cycle_s1 <= din.cycle;
		end
	end

	tebd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (s1_fire),
		.func            (func_s1),
		.cycle           (cycle_s1),
		.short_threshold (short_threshold_q),
		.silence_limit   (silence_limit_q),
		.res             (res)
	);

	// Output register: loaded with a finished byte, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.emit) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			out_byte_q <= res.byte_value;
		end
	end

	assign dout.valid      = out_vld_q;
	assign dout.byte_value = out_byte_q;

	// A byte is never produced over one that is still waiting.
	`TEBD_ASSERT_NOW(a_no_overwrite, clk, arst_n, res.emit, !out_vld_q || dout.ready)
	// Every produced byte shows up on the output in the next cycle.
	`TEBD_ASSERT_NEXT(a_emit_shown, clk, arst_n, res.emit, dout.valid)
	// Stage 1 only takes a new beat when its current item leaves.
	`TEBD_ASSERT_NOW(a_s1_no_loss, clk, arst_n, in_fire && vld_s1, s1_fire)

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tape edge bit decoder testbench
// Drives edge and finish items into the decoder under several register
// settings and flow-control patterns. Every decoded byte is checked against
// a cycle-free software copy of the decoder.
// ----------------------------------------------------------------------------
module tb;
	import tebd_pkg::*;

	// Directed stimulus rows. An edge row gives either an absolute cycle or a
	// step from the last edge cycle, repeated reps times. A typed row carries
	// the byte its last item must produce.
	typedef enum logic [1:0] {
		ROW_EDGE_AT,
		ROW_EDGE_STEP,
		ROW_FINISH
	} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [CYCLE_W-1:0] arg;
		int                reps;
		bit                typed;
		logic [BYTE_W-1:0] byte_exp;
	} stim_row_t;

	// One phase of the random run: register values and flow-control pressure.
	typedef struct {
		logic [CFG_W-1:0] thr;
		logic [CFG_W-1:0] sil;
		int unsigned      send_pct;
		int unsigned      stall_pct;
	} phase_t;

	localparam int PHASE_ITEMS = 120;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_WAIT_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic rx_ready = 1'b0;

	tebd_in_if din ();
	tebd_out_if dout ();

	assign dout.ready = rx_ready;

	tape_edge_bit_decoder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din),
		.dout      (dout)
	);

	// The directed part runs with the reset register values. It covers the
	// first edge, a zero-length half period, a finish that completes a byte,
	// a finish with no open burst, the cycle counter wrapping past its top,
	// both sides of the short threshold and of the silence limit, a cycle
	// going backwards, and a finish in the middle of a group.
	stim_row_t dir_tab [14] = '{
		'{ROW_EDGE_AT,   64'd0,                  1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd0,                  31, 1'b0, 8'h00},
		'{ROW_FINISH,    64'd0,                  1,  1'b1, 8'hFF},
		'{ROW_FINISH,    64'd0,                  1,  1'b0, 8'h00},
		'{ROW_EDGE_AT,   64'hFFFF_FFFF_FFFF_FFFF, 1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd1,                  1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd738,                1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd739,                1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd7808,               1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd7809,               1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd7808,               1,  1'b0, 8'h00},
		'{ROW_EDGE_AT,   64'd3,                  1,  1'b0, 8'h00},
		'{ROW_EDGE_STEP, 64'd5,                  2,  1'b0, 8'h00},
		'{ROW_FINISH,    64'd0,                  1,  1'b0, 8'h00}
	};

	// Random phases. The settings include the reset values, a zero threshold,
	// a zero silence limit and the largest values. Phase 5 is filled in with
	// random register values at the start of the run.
	phase_t phase_tab [8] = '{
		'{16'd739,   16'd7808,  0,  0},
		'{16'd0,     16'd65535, 86, 0},
		'{16'd65535, 16'd65535, 0,  86},
		'{16'd1,     16'd0,     36, 36},
		'{16'd400,   16'd3000,  0,  0},
		'{16'd739,   16'd7808,  86, 0},
		'{16'd65535, 16'd1,     0,  86},
		'{16'd739,   16'd7808,  36, 36}
	};

	// Software copy of the decoder: registers and state.
	logic [CFG_W-1:0] thr_cfg;
	logic [CFG_W-1:0] sil_cfg;
	bit have_edge;
	logic [CYCLE_W-1:0] prev_cycle;
	logic [1:0] half_cnt;
	logic [2:0] short_cnt;
	logic [2:0] bit_cnt;
	logic [BYTE_W-1:0] shreg;
	bit in_burst;
	bit prev_short;

	// Bytes the decoder has yet to deliver, oldest first.
	logic [BYTE_W-1:0] pending_bytes [$];

	int unsigned send_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned phase_items = 0;
	int unsigned err_count = 0;
	logic [CYCLE_W-1:0] drv_cycle = '0;

	// Free-running clock, 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#4_000_000;
		$display("tb failed");
		$finish;
	end

	// Drop any partial group, bit and byte.
	function automatic void decoder_clear();
		half_cnt = '0;
		short_cnt = '0;
		bit_cnt = '0;
		shreg = '0;
		in_burst = 1'b0;
		prev_short = 1'b0;
	endfunction

	// Account one half period by its shortness. Four halves make a bit, eight
	// bits make a byte; returns 1 with the byte when one is complete.
	function automatic bit feed_half(input bit is_short, output logic [BYTE_W-1:0] val);
		bit b;
		val = '0;
		in_burst = 1'b1;
		prev_short = is_short;
		if (is_short)
			short_cnt++;
		if (half_cnt < 2'd3) begin
			half_cnt++;
			return 1'b0;
		end
		b = (short_cnt >= 3'd2);
		half_cnt = '0;
		short_cnt = '0;
		shreg = {shreg[BYTE_W-2:0], b};
		if (bit_cnt < 3'd7) begin
			bit_cnt++;
			return 1'b0;
		end
		val = shreg;
		bit_cnt = '0;
		shreg = '0;
		return 1'b1;
	endfunction

	// Expected outcome of one accepted item.
	function automatic bit decode_item(input logic fn, input logic [CYCLE_W-1:0] cyc,
		output logic [BYTE_W-1:0] val);
		logic [CYCLE_W-1:0] span;
		bit got;
		got = 1'b0;
		val = '0;
		if (fn == FUNC_FINISH) begin
			// A finish replays the last half of an open burst, then forgets
			// everything including the last edge.
			if (in_burst)
				got = feed_half(prev_short, val);
			decoder_clear();
			have_edge = 1'b0;
			return got;
		end
		if (have_edge) begin
			span = cyc - prev_cycle;
			if (span > {{(CYCLE_W-CFG_W){1'b0}}, sil_cfg})
				decoder_clear();
			else
				got = feed_half(span < {{(CYCLE_W-CFG_W){1'b0}}, thr_cfg}, val);
		end
		prev_cycle = cyc;
		have_edge = 1'b1;
		return got;
	endfunction

	// Pick a half period that does not end the burst, short or long as asked.
	// When the threshold is above the silence limit, every surviving half is
	// short; with a zero threshold none is.
	function automatic logic [CYCLE_W-1:0] pick_span(input bit want_short);
		int unsigned t;
		int unsigned s;
		int unsigned lo;
		int unsigned hi;
		t = thr_cfg;
		s = sil_cfg;
		if ((want_short && t != 0) || t > s) begin
			lo = 0;
			hi = (t - 1 < s) ? t - 1 : s;
		end else begin
			lo = t;
			hi = s;
		end
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic logic [CYCLE_W-1:0] rand_cycle();
		return {$urandom, $urandom};
	endfunction

	task automatic report_miss(input string what, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] seen);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s: expected %02h, got %02h", $realtime, what, want, seen);
	endtask

	// Present one item and hold it until the decoder takes the beat. Valid is
	// only lowered when a gap is inserted, so it never toggles within a step.
	task automatic send_item(input logic fn, input logic [CYCLE_W-1:0] cyc, output bit got);
		logic [BYTE_W-1:0] val;
		if ($urandom_range(0, 99) < send_pct) begin
			din.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_pct);
		end
		din.valid <= 1'b1;
		din.func <= fn;
		din.cycle <= cyc;
		do
			@(posedge clk);
		while (!din.ready);
		got = decode_item(fn, cyc, val);
		if (got)
			pending_bytes = {pending_bytes, val};
		if (fn == FUNC_EDGE)
			drv_cycle = cyc;
		phase_items++;
	endtask

	// Stop sending and wait for every outstanding byte to come out.
	task automatic drain();
		din.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_bytes.size() != 0);
	endtask

	// Registers change only with the decoder idle. Items that produce no byte
	// may still be in flight, so a settle wait follows the drain.
	task automatic write_regs(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] sil);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SHORT_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_SILENCE_LIMIT;
		cfg_data <= sil;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_cfg = thr;
		sil_cfg = sil;
	endtask

	// One burst: a fresh reference edge, then whole bytes of halves with
	// random shortness. A tenth of the bursts stop at a random point, a tenth
	// stop one half short and rely on the finish replay, and a tenth are
	// followed by random noise items.
	task automatic run_burst();
		int style;
		int nhalves;
		int k;
		bit got;
		style = $urandom_range(0, 9);
		case ($urandom_range(0, 2))
			0: begin
				send_item(FUNC_FINISH, rand_cycle(), got);
				send_item(FUNC_EDGE, rand_cycle(), got);
			end
			1: send_item(FUNC_EDGE,
				drv_cycle + sil_cfg + 64'd1 + $urandom_range(0, 4095), got);
			default: send_item(FUNC_EDGE, rand_cycle(), got);
		endcase
		nhalves = 32 * $urandom_range(1, 3);
		if (style == 0)
			nhalves = $urandom_range(1, nhalves);
		else if (style == 1)
			nhalves = nhalves - 1;
		for (k = 0; k < nhalves; k++)
			send_item(FUNC_EDGE, drv_cycle + pick_span(1'($urandom_range(0, 1))), got);
		if (style == 1) begin
			send_item(FUNC_FINISH, rand_cycle(), got);
		end else if (style == 2) begin
			for (k = $urandom_range(1, 4); k > 0; k--)
				send_item(1'($urandom_range(0, 1)), rand_cycle(), got);
		end
	endtask

	// The receiver stalls at random, as hard as the current phase asks.
	always @(posedge clk)
		rx_ready <= ($urandom_range(0, 99) >= stall_pct);

	// Every byte beat is matched against the oldest expected byte.
	always @(posedge clk) begin : byte_check
		logic [BYTE_W-1:0] want;
		if (arst_n && dout.valid && dout.ready) begin
			if (pending_bytes.size() == 0) begin
				report_miss("unexpected byte", 8'h00, dout.byte_value);
			end else begin
				want = pending_bytes.pop_front();
				if (dout.byte_value !== want)
					report_miss("byte mismatch", want, dout.byte_value);
			end
		end
	end

	// Main sequence: reset, directed table, then the random phases, then the
	// final drain and verdict.
	initial begin : main_seq
		int k;
		int p;
		int waited;
		bit got;
		bit paused;
		logic fn;
		logic [CYCLE_W-1:0] cyc;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SHORT_THRESHOLD;
		cfg_data = '0;
		din.valid = 1'b0;
		din.func = FUNC_EDGE;
		din.cycle = '0;

		thr_cfg = SHORT_THRESHOLD_RST;
		sil_cfg = SILENCE_LIMIT_RST;
		have_edge = 1'b0;
		prev_cycle = '0;
		decoder_clear();
		paused = 1'b0;

		phase_tab[5].thr = $urandom_range(1, 65535);
		phase_tab[5].sil = $urandom_range(1, 65535);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A typed row's last beat must give the typed byte,
		// which then stands in for whatever the software copy predicted.
		foreach (dir_tab[r]) begin
			for (k = 0; k < dir_tab[r].reps; k++) begin
				fn = (dir_tab[r].kind == ROW_FINISH) ? FUNC_FINISH : FUNC_EDGE;
				case (dir_tab[r].kind)
					ROW_EDGE_AT: cyc = dir_tab[r].arg;
					ROW_EDGE_STEP: cyc = drv_cycle + dir_tab[r].arg;
					default: cyc = rand_cycle();
				endcase
				send_item(fn, cyc, got);
				if (dir_tab[r].typed && k == dir_tab[r].reps - 1) begin
					if (got)
						pending_bytes[pending_bytes.size() - 1] = dir_tab[r].byte_exp;
					else
						pending_bytes = {pending_bytes, dir_tab[r].byte_exp};
				end
			end
		end

		// Random phases, each under its own register setting and pressure.
		for (p = 0; p < 8; p++) begin
			write_regs(phase_tab[p].thr, phase_tab[p].sil);
			send_pct = phase_tab[p].send_pct;
			stall_pct = phase_tab[p].stall_pct;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				run_burst();
				// Once in the run, hold off the sender until the output has
				// caught up completely.
				if (p == 1 && !paused && phase_items >= 60) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		// Let every byte out, then give the pipeline time to show anything
		// spurious.
		din.valid <= 1'b0;
		stall_pct = 0;
		waited = 0;
		while (pending_bytes.size() != 0 && waited < END_WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (pending_bytes.size() != 0)
			report_miss("byte never delivered", pending_bytes[0], 8'h00);

		if (err_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
